FILE: design/fbli_pkg.sv
// Package for the free block list insert block: sizes, status codes,
// controller states and the memory request types. No dependencies.
`default_nettype none

package fbli_pkg;

    localparam int DISK_BLOCKS         = 1024;
    localparam int ENTRIES_PER_SEGMENT = 64;
    localparam int MAX_SEGMENTS        = 16;

    localparam int BLK_W       = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    localparam int ENTRY_DEPTH = MAX_SEGMENTS * ENTRIES_PER_SEGMENT;
    localparam int SEG_W       = $clog2(MAX_SEGMENTS + 1);
    localparam int FILL_W      = $clog2(ENTRIES_PER_SEGMENT + 1);
    localparam int ENT_CW      = $clog2(ENTRY_DEPTH + 1);
    localparam int HEAD_AW     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int ENT_AW      = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_ENT,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic               we;
        logic [HEAD_AW-1:0] addr;
        logic [BLK_W-1:0]   wdata;
    } t_head_req;

    typedef struct packed {
        logic              we;
        logic [ENT_AW-1:0] addr;
        logic [BLK_W-1:0]  wdata;
    } t_ent_req;

    typedef struct packed {
        t_status status;
        logic    new_segment;
    } t_result;

endpackage

`default_nettype wire

FILE: design/fbli_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing; width and depth come in as parameters.
`default_nettype none

module fbli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

FILE: design/fbli_ctrl.sv
// Controller of the free block list insert block: duplicate scan over the
// head and entry memories, then the decision and write-back. Uses fbli_pkg.
`default_nettype none

module fbli_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic [fbli_pkg::BLK_W-1:0] i_block,
    output logic                          o_in_ready,
    input  wire logic                     i_out_free,
    output logic                          o_res_valid,
    output fbli_pkg::t_result             o_res,
    output fbli_pkg::t_head_req           o_head_req,
    input  wire logic [fbli_pkg::BLK_W-1:0] i_head_rdata,
    output fbli_pkg::t_ent_req            o_ent_req,
    input  wire logic [fbli_pkg::BLK_W-1:0] i_ent_rdata
);
    import fbli_pkg::*;

    localparam int IDX_W = ENT_CW;

    t_state              r_state, n_state;
    logic [SEG_W-1:0]    r_used, n_used;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [ENT_CW-1:0]   r_total, n_total;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [BLK_W-1:0]    r_blk, n_blk;
    logic                r_inv, n_inv;
    logic                r_dup, n_dup;
    logic                r_pend_head, n_pend_head;
    logic                r_pend_ent, n_pend_ent;
    logic                w_dup_now;

    // A read issued last cycle is compared here, so the last one still
    // counts when the decision is taken.
    assign w_dup_now = r_dup
                     | (r_pend_head && (i_head_rdata == r_blk))
                     | (r_pend_ent && (i_ent_rdata == r_blk));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_fill      <= '0;
            r_total     <= '0;
            r_pend_head <= 1'b0;
            r_pend_ent  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_fill      <= n_fill;
            r_total     <= n_total;
            r_pend_head <= n_pend_head;
            r_pend_ent  <= n_pend_ent;
        end
        r_idx <= n_idx;
        r_blk <= n_blk;
        r_inv <= n_inv;
        r_dup <= n_dup;
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_fill      = r_fill;
        n_total     = r_total;
        n_idx       = r_idx;
        n_blk       = r_blk;
        n_inv       = r_inv;
        n_dup       = w_dup_now;
        n_pend_head = 1'b0;
        n_pend_ent  = 1'b0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{status: ST_OK, new_segment: 1'b0};
        o_head_req  = '{we: 1'b0, addr: r_idx[HEAD_AW-1:0], wdata: r_blk};
        o_ent_req   = '{we: 1'b0, addr: r_idx[ENT_AW-1:0], wdata: r_blk};

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_blk   = i_block;
                    n_inv   = (i_block < BLK_W'(2)) || (32'(i_block) >= DISK_BLOCKS);
                    n_dup   = 1'b0;
                    n_idx   = '0;
                    n_state = n_inv ? S_DECIDE : S_HEAD;
                end
            end
            S_HEAD: begin
                if (r_idx < IDX_W'(r_used)) begin
                    n_pend_head = 1'b1;
                    n_idx       = r_idx + IDX_W'(1);
                end else begin
                    n_idx   = '0;
                    n_state = S_ENT;
                end
            end
            S_ENT: begin
                if (r_idx < r_total) begin
                    n_pend_ent = 1'b1;
                    n_idx      = r_idx + IDX_W'(1);
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = S_IDLE;
                    priority if (r_inv) begin
                        o_res.status = ST_INVALID;
                    end else if (w_dup_now) begin
                        o_res.status = ST_DUPLICATE;
                    end else if ((r_used != '0) && (r_fill < FILL_W'(ENTRIES_PER_SEGMENT))) begin
                        // Room left in the last segment: append an entry.
                        o_ent_req.we   = 1'b1;
                        o_ent_req.addr = r_total[ENT_AW-1:0];
                        n_fill         = r_fill + FILL_W'(1);
                        n_total        = r_total + ENT_CW'(1);
                    end else if (r_used >= SEG_W'(MAX_SEGMENTS)) begin
                        o_res.status = ST_FULL;
                    end else begin
                        // No segment yet, or the last one is full.
                        o_res.new_segment = 1'b1;
                        o_head_req.we     = 1'b1;
                        o_head_req.addr   = r_used[HEAD_AW-1:0];
                        n_used            = r_used + SEG_W'(1);
                        n_fill            = '0;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= SEG_W'(MAX_SEGMENTS))
        else $error("segment count past its maximum");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(ENTRIES_PER_SEGMENT))
        else $error("segment fill past its maximum");

    a_new_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.new_segment) |-> (o_res.status == ST_OK))
        else $error("new segment flagged on a rejected block");

    a_new_clears_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.new_segment) |=> (r_fill == '0))
        else $error("fill not cleared after a new segment");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_head_req.we || o_ent_req.we) |-> (r_state == S_DECIDE))
        else $error("memory written outside the decision step");

endmodule

`default_nettype wire

FILE: design/free_block_list_insert_top.sv
// An item passes through the controller's head scan over the segments in use, its entry
// scan over the stored entries and its decision step; at most 1022 distinct blocks can be
// on the list. Invalid block numbers skip the scan and go straight to the decision.
// Throughput: one item at a time; the duplicate scan, one read of the head or entry
// memory per cycle, sets the rate. A result waits in an output register, so the
// next input beat is taken while it is pending.
// Reset (synchronous, active low) empties the list; the memories are not cleared.
`default_nettype none

module free_block_list_insert_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input stream. tdata: block_number [9:0], zero padding [15:10].
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [fbli_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // Result stream. tdata: status [1:0], new_segment [2], zero padding [7:3].
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    output logic      [fbli_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);
    import fbli_pkg::*;

    t_head_req         w_head_req;
    t_ent_req          w_ent_req;
    logic [BLK_W-1:0]  w_head_rdata;
    logic [BLK_W-1:0]  w_ent_rdata;
    logic              w_res_valid;
    t_result           w_res;
    logic              w_out_free;

    logic              r_out_valid;
    t_result           r_out;

    // The output register can take a new result when it is empty or its
    // current beat leaves this cycle.
    assign w_out_free = !r_out_valid || i_m_tready;

    fbli_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_tvalid),
        .i_block      (i_s_tdata[BLK_W-1:0]),
        .o_in_ready   (o_s_tready),
        .i_out_free   (w_out_free),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res),
        .o_head_req   (w_head_req),
        .i_head_rdata (w_head_rdata),
        .o_ent_req    (w_ent_req),
        .i_ent_rdata  (w_ent_rdata)
    );

    // Head block of each segment.
    fbli_ram #(
        .WIDTH (BLK_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_head_req.we),
        .i_addr  (w_head_req.addr),
        .i_wdata (w_head_req.wdata),
        .o_rdata (w_head_rdata)
    );

    // Entries of all segments, stored back to back: every segment but the
    // last is full, so entry k of segment s sits at s * ENTRIES_PER_SEGMENT + k.
    fbli_ram #(
        .WIDTH (BLK_W),
        .DEPTH (ENTRY_DEPTH)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_req.we),
        .i_addr  (w_ent_req.addr),
        .i_wdata (w_ent_req.wdata),
        .o_rdata (w_ent_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - 3)'(0), r_out.new_segment, r_out.status};

endmodule

`default_nettype wire
